FILE: rtl/core/shell_argument_quoter_top_defines.svh
// assertion macros for the shell argument quoter
`ifndef SHELL_ARGUMENT_QUOTER_TOP_DEFINES_SVH
`define SHELL_ARGUMENT_QUOTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SAQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("saq assertion failed");
`define SAQ_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("saq forbidden condition");
`else
`define SAQ_ASSERT(lbl, clk, rstn, prop)
`define SAQ_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

FILE: rtl/core/saq_pkg.sv
// types and constants shared by the shell argument quoter
`timescale 1ns / 1ps
package saq_pkg;

    localparam int OUT_MAX = 7;

    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_BANG    = 8'h21;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;

    localparam logic CFG_QUOTE_ENABLE = 1'b0;
    localparam logic CFG_SHELL_MODE   = 1'b1;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       starts_arg;
        logic       ends_arg;
        logic       no_char;
    } t_in_req;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_req;

    typedef struct packed {
        logic [OUT_MAX-1:0][7:0] bytes;
        logic [2:0]              count;
    } t_plan;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

FILE: rtl/core/saq_front.sv
// front end: config registers and expansion of one request into a byte plan
`timescale 1ns / 1ps
module saq_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic             i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  saq_pkg::t_in_req i_in_req,
    input  logic             i_q_full,
    output logic             o_push,
    output saq_pkg::t_plan   o_plan
);
    import saq_pkg::*;

    logic            r_quote_enable;
    logic            r_shell_mode;
    logic [3:0][7:0] enc;
    logic [2:0]      enc_n;
    logic [1:0][7:0] pre;
    logic [2:0]      pre_n;
    logic [2:0]      suf_n;
    logic [2:0]      pre_enc_n;
    logic [2:0]      rel;
    logic [7:0]      c;
    logic            other_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote_enable <= 1'b1;
            r_shell_mode   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_QUOTE_ENABLE: r_quote_enable <= i_cfg_data;
                CFG_SHELL_MODE:   r_shell_mode   <= i_cfg_data;
                default:          r_shell_mode   <= r_shell_mode;
            endcase
        end
    end

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // escape the data byte
    always_comb begin
        c           = i_in_req.char_byte;
        other_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
                      (c == CH_FF) || (c == CH_CR);
        enc         = {CH_SQUOTE, CH_SQUOTE, CH_SQUOTE, CH_SQUOTE};
        enc_n       = 3'd1;
        enc[0]      = c;
        if (!r_quote_enable) begin
            enc_n = 3'd1;
        end else if (r_shell_mode && c == CH_BSLASH) begin
            enc[1] = CH_BSLASH;
            enc_n  = 3'd2;
        end else if (r_shell_mode && (c == CH_BANG || other_space)) begin
            enc[0] = CH_SQUOTE;
            enc[1] = CH_BSLASH;
            enc[2] = c;
            enc[3] = CH_SQUOTE;
            enc_n  = 3'd4;
        end else if (r_shell_mode && c == CH_NL) begin
            enc[0] = CH_BSLASH;
            enc[1] = CH_LOWER_N;
            enc_n  = 3'd2;
        end else if (c == CH_SQUOTE) begin
            enc[0] = CH_SQUOTE;
            enc[1] = CH_BSLASH;
            enc[2] = CH_SQUOTE;
            enc[3] = CH_SQUOTE;
            enc_n  = 3'd4;
        end
        if (i_in_req.no_char) begin
            enc_n = 3'd0;
        end
    end

    // lay out opening part, escaped byte and closing quote
    always_comb begin
        pre       = {CH_SQUOTE, CH_SPACE};
        pre_n     = i_in_req.starts_arg ? (r_quote_enable ? 3'd2 : 3'd1) : 3'd0;
        suf_n     = (i_in_req.ends_arg && r_quote_enable) ? 3'd1 : 3'd0;
        pre_enc_n = pre_n + enc_n;
        rel       = 3'd0;
        o_plan    = '0;
        for (int k = 0; k < OUT_MAX; k++) begin
            rel = 3'(k) - pre_n;
            if (3'(k) < pre_n) begin
                o_plan.bytes[k] = pre[k[0]];
            end else if (3'(k) < pre_enc_n) begin
                o_plan.bytes[k] = enc[rel[1:0]];
            end else begin
                o_plan.bytes[k] = CH_SQUOTE;
            end
        end
        o_plan.count = pre_enc_n + suf_n;
    end

endmodule

FILE: rtl/core/saq_queue.sv
// short plan queue between front and back ends
`timescale 1ns / 1ps
module saq_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  saq_pkg::t_plan      i_plan,
    input  logic                i_pop,
    output saq_pkg::t_plan      o_plan,
    output saq_pkg::t_q_status  o_status
);
    import saq_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_plan           r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_plan         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_plan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/core/saq_back.sv
// back end: emits a plan one byte per cycle unless stalled, via an output register
`timescale 1ns / 1ps
module saq_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  saq_pkg::t_plan    i_plan,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output saq_pkg::t_out_req o_out_req
);
    import saq_pkg::*;

    logic [2:0] r_idx;
    logic [2:0] n_idx;
    logic       r_out_valid;
    logic       n_out_valid;
    t_out_req   r_out;
    t_out_req   n_out;
    logic       can_load;
    logic       is_last;

    always_comb begin
        can_load    = !r_out_valid || !i_out_stall;
        is_last     = (r_idx == i_plan.count - 3'd1);
        n_idx       = r_idx;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_pop       = 1'b0;
        if (i_q_valid && i_plan.count == 3'd0) begin
            // nothing to emit for this request
            o_pop = 1'b1;
            n_idx = 3'd0;
        end else if (i_q_valid && can_load) begin
            n_out.out_byte    = i_plan.bytes[r_idx];
            n_out.last_of_run = is_last;
            n_out_valid       = 1'b1;
            if (is_last) begin
                o_pop = 1'b1;
                n_idx = 3'd0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_idx       <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

FILE: rtl/core/shell_argument_quoter_top.sv
// first byte of a request is written to the plan queue, then to the output register
// throughput: one output byte per cycle while the output is not stalled;
// a request yields 0 to 7 output bytes, all through the single output port
// a new request is taken every cycle while the plan queue has room
// reset: synchronous active low; empties the queue and output, quoting on, shell mode off
`timescale 1ns / 1ps
`include "shell_argument_quoter_top_defines.svh"
module shell_argument_quoter_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  saq_pkg::t_in_req  i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output saq_pkg::t_out_req o_out_req
);
    import saq_pkg::*;

    logic      push;
    logic      pop;
    t_plan     front_plan;
    t_plan     head_plan;
    t_q_status q_status;

    saq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .i_q_full    (q_status.full),
        .o_push      (push),
        .o_plan      (front_plan)
    );

    saq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_plan   (front_plan),
        .i_pop    (pop),
        .o_plan   (head_plan),
        .o_status (q_status)
    );

    saq_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (!q_status.empty),
        .i_plan      (head_plan),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req)
    );

    `SAQ_ASSERT_NEVER(a_queue_full_and_empty, i_clk, i_rst_n, q_status.full && q_status.empty)
    `SAQ_ASSERT(a_stall_only_when_full, i_clk, i_rst_n, o_in_stall |-> q_status.full)
    `SAQ_ASSERT(a_push_lands, i_clk, i_rst_n, push |=> !q_status.empty)

endmodule
